FILE: sv/u8l1_pkg.sv
`default_nettype none

package u8l1_pkg;

    // Latin-1 replacement character
    localparam logic [7:0] REPL_CHAR = 8'h3F;

    // One result item as it leaves the block
    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       final_result;
    } t_res;

    // Results caused by one input item, in order; n_res is 0, 1 or 2
    typedef struct packed {
        logic [1:0] n_res;
        t_res       res0;
        t_res       res1;
    } t_dec_res;

endpackage

`default_nettype wire

FILE: sv/u8l1_if.sv
`default_nettype none

// Byte stream into the decoder
interface u8l1_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

// Latin-1 character stream out of the decoder
interface u8l1_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       char_valid;
    logic       final_result;

    modport source (output valid, output out_char, output char_valid, output final_result,
                    input ready);
    modport sink   (input valid, input out_char, input char_valid, input final_result,
                    output ready);
endinterface

`default_nettype wire

FILE: sv/u8l1_decode.sv
`default_nettype none

module u8l1_decode (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire logic [7:0]          i_byte,
    input  wire logic                i_eot,
    output u8l1_pkg::t_dec_res       o_res
);
    import u8l1_pkg::*;

    logic [1:0]  r_pend;
    logic [20:0] r_acc;
    logic        r_skip;
    logic [1:0]  n_pend;
    logic [20:0] n_acc;
    logic        n_skip;

    logic        cont;
    logic [20:0] acc_shift;
    logic        e_cut;
    logic        e_main;
    logic        e_eot;
    logic [7:0]  main_char;
    logic [1:0]  cnt;

    assign cont      = (i_byte[7:6] == 2'b10);
    assign acc_shift = {r_acc[14:0], i_byte[5:0]};

    // Next state and the characters this item causes
    always_comb begin
        n_pend    = r_pend;
        n_acc     = r_acc;
        n_skip    = r_skip;
        e_cut     = 1'b0;
        e_main    = 1'b0;
        main_char = REPL_CHAR;
        if (r_skip && cont) begin
            // drop stray continuation byte
        end else begin
            n_skip = 1'b0;
            if (r_pend != 2'd0 && cont) begin
                n_acc  = acc_shift;
                n_pend = r_pend - 2'd1;
                if (r_pend == 2'd1) begin
                    e_main    = 1'b1;
                    main_char = (|acc_shift[20:8]) ? REPL_CHAR : acc_shift[7:0];
                    n_acc     = '0;
                end
            end else begin
                // sequence cut short: flag it, then treat the byte as a lead
                if (r_pend != 2'd0) begin
                    e_cut  = 1'b1;
                    n_pend = 2'd0;
                    n_acc  = '0;
                end
                if (!i_byte[7]) begin
                    e_main    = 1'b1;
                    main_char = i_byte;
                end else if (i_byte[7:5] == 3'b110) begin
                    n_acc  = {16'd0, i_byte[4:0]};
                    n_pend = 2'd1;
                end else if (i_byte[7:4] == 4'b1110) begin
                    n_acc  = {17'd0, i_byte[3:0]};
                    n_pend = 2'd2;
                end else if (i_byte[7:3] == 5'b11110) begin
                    n_acc  = {18'd0, i_byte[2:0]};
                    n_pend = 2'd3;
                end else begin
                    e_main    = 1'b1;
                    main_char = REPL_CHAR;
                    n_skip    = 1'b1;
                end
            end
        end
        e_eot = i_eot && (n_pend != 2'd0);
        if (i_eot) begin
            n_pend = 2'd0;
            n_acc  = '0;
            n_skip = 1'b0;
        end
    end

    // Order the results: cut-short mark, main character, end-of-text mark
    always_comb begin
        cnt = {1'b0, e_cut} + {1'b0, e_main} + {1'b0, e_eot};
        if (cnt == 2'd3) begin
            cnt = 2'd2;
        end
        o_res.res0.out_char     = (!e_cut && e_main) ? main_char : REPL_CHAR;
        o_res.res0.char_valid   = 1'b1;
        o_res.res0.final_result = i_eot && (cnt == 2'd1);
        o_res.res1.out_char     = (e_cut && e_main) ? main_char : REPL_CHAR;
        o_res.res1.char_valid   = 1'b1;
        o_res.res1.final_result = i_eot;
        if (i_eot && cnt == 2'd0) begin
            // marker only
            o_res.res0.out_char     = 8'd0;
            o_res.res0.char_valid   = 1'b0;
            o_res.res0.final_result = 1'b1;
            cnt = 2'd1;
        end
        o_res.n_res = cnt;
    end

    // Hold decoder state between items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_acc  <= '0;
            r_skip <= 1'b0;
        end else if (i_accept) begin
            r_pend <= n_pend;
            r_acc  <= n_acc;
            r_skip <= n_skip;
        end
    end

    a_skip_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_skip && r_pend != 2'd0))
        else $error("skip mode while a sequence is pending");
    a_acc_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend == 2'd0) |-> (r_acc == 21'd0))
        else $error("accumulator not clear with nothing pending");
    a_eot_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_eot) |=> (r_pend == 2'd0 && !r_skip && r_acc == 21'd0))
        else $error("state not cleared after end of text");
    a_eot_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_eot) |-> (o_res.n_res != 2'd0))
        else $error("end of text gave no result");

endmodule

`default_nettype wire

FILE: sv/u8l1_outq.sv
`default_nettype none

module u8l1_outq (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire u8l1_pkg::t_dec_res  i_res,
    output logic                     o_space,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output u8l1_pkg::t_res           o_head
);
    import u8l1_pkg::*;

    logic [1:0] r_cnt;
    t_res       r_q0;
    t_res       r_q1;
    logic       pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_q0;
    // Room for two results once the head leaves
    assign o_space = (r_cnt == 2'd0) || (r_cnt == 2'd1 && pop);

    // Count results held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_push) begin
            r_cnt <= i_res.n_res;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // Load a fresh pair or advance the second slot to the head
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q0 <= i_res.res0;
            r_q1 <= i_res.res1;
        end else if (pop) begin
            r_q0 <= r_q1;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result queue count out of range");
    a_push_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |=> (r_cnt == $past(i_res.n_res)))
        else $error("result queue not loaded with new results");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt == 2'd0 || pop))
        else $error("results pushed over undelivered results");

endmodule

`default_nettype wire

FILE: sv/utf8_to_latin1_stream_decoder.sv
// A result item is registered in the result queue and offered in the cycle
// after its byte is accepted. One byte per cycle while each byte yields at
// most one result and the output is ready; a byte that yields two results
// holds the next byte until the two-entry result queue drains to one entry.
// Reset: synchronous, active low; clears decoder state and empties the queue.
`default_nettype none

module utf8_to_latin1_stream_decoder (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    u8l1_in_if.sink    i_in,
    u8l1_out_if.source o_out
);
    import u8l1_pkg::*;

    logic     accept;
    logic     space;
    t_dec_res dec_res;
    t_res     head;

    assign i_in.ready = space;
    assign accept     = i_in.valid && space;

    u8l1_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in.in_byte),
        .i_eot    (i_in.end_of_text),
        .o_res    (dec_res)
    );

    u8l1_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_res   (dec_res),
        .o_space (space),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_head  (head)
    );

    assign o_out.out_char     = head.out_char;
    assign o_out.char_valid   = head.char_valid;
    assign o_out.final_result = head.final_result;

endmodule

`default_nettype wire
